// ===== rtl/spbc_pkg.sv =====
`default_nettype none

package spbc_pkg;

  localparam int SAMPLE_W = 24;
  localparam int COEF_W   = 32;
  localparam int OP_W     = 2;
  localparam int CIDX_W   = 6;

  // operation codes
  localparam logic [OP_W-1:0] OP_PROCESS = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD    = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]            operation;
    logic signed [SAMPLE_W-1:0] left_in;
    logic signed [SAMPLE_W-1:0] right_in;
    logic [CIDX_W-1:0]          coef_index;
    logic signed [COEF_W-1:0]   coef_value;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
  } out_item_t;

  // one history row: one section, one channel
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] x1;
    logic signed [SAMPLE_W-1:0] x2;
    logic signed [SAMPLE_W-1:0] y1;
    logic signed [SAMPLE_W-1:0] y2;
  } hist_row_t;

endpackage

`default_nettype wire

// ===== rtl/stereo_peaking_biquad_cascade.sv =====
// channel   | signals                      | moves
// ----------+------------------------------+----------------------------------
// in        | in_valid, in_stall, in_data  | process / load / clear transaction
// out       | out_valid, out_stall, out_data | filtered stereo pair
// config    | cfg_we, cfg_wdata            | bypass register write
//
// one shared 32x25 multiplier runs a tap schedule for each section of each channel.
// load, clear and ignored codes leave the sequencer idle; a bypassed pair goes
// straight to the finish step.
// reset and clear invalidate every history row at once through row valid bits.
// a finished pair waits in the output register while out_stall is high.
`default_nettype none

module stereo_peaking_biquad_cascade #(
  parameter int BANDS          = 4,
  parameter int COEF_FRAC_BITS = 28
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output      logic                in_stall,
  input  wire spbc_pkg::in_item_t  in_data,
  output      logic                out_valid,
  input  wire logic                out_stall,
  output      spbc_pkg::out_item_t out_data,
  input  wire logic                cfg_we,
  input  wire logic                cfg_wdata
);
  import spbc_pkg::*;

  localparam int SECTIONS   = 2 * BANDS;
  localparam int ROWS       = 4 * BANDS;
  localparam int COEF_WORDS = 10 * BANDS;
  localparam int SEC_W      = $clog2(SECTIONS);
  localparam int ROW_W      = SEC_W + 1;
  localparam int CA_W       = $clog2(COEF_WORDS);
  localparam int OPND_W     = SAMPLE_W + 1;
  localparam int PROD_W     = COEF_W + OPND_W;
  localparam int ACC_W      = 60;
  localparam int RND_W      = ACC_W + 1;

  localparam logic signed [RND_W-1:0] RND_HALF = RND_W'(1) <<< (COEF_FRAC_BITS - 1);
  localparam logic signed [RND_W-1:0] SAT_HI   = RND_W'(8388607);
  localparam logic signed [RND_W-1:0] SAT_LO   = -RND_W'(8388608);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_RUN    = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  localparam logic [2:0] TAP_LAST = 3'd7;

  // control state
  logic [1:0]       state;
  logic [SEC_W-1:0] sec;
  logic             ch;
  logic [2:0]       tap;
  logic [CA_W-1:0]  coef_base;
  logic             bypass;
  logic [ROWS-1:0]  row_vld;

  // datapath registers
  logic signed [SAMPLE_W-1:0] cur_l;
  logic signed [SAMPLE_W-1:0] cur_r;
  logic signed [COEF_W-1:0]   coef_rd;
  hist_row_t                  hist_rd;
  logic                       row_hit;
  logic signed [PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]    acc;

  // memories
  logic signed [COEF_W-1:0] coef_mem [COEF_WORDS];
  hist_row_t                hist_mem [ROWS];

  logic                       in_acc;
  logic                       coef_we;
  logic [CA_W-1:0]            coef_waddr;
  logic                       coef_re;
  logic [CA_W-1:0]            coef_addr;
  logic [ROW_W-1:0]           row;
  logic                       hist_re;
  logic                       hist_we;
  hist_row_t                  hist_cur;
  hist_row_t                  hist_wr;
  logic signed [SAMPLE_W-1:0] x_cur;
  logic signed [OPND_W-1:0]   opnd;
  logic signed [RND_W-1:0]    rnd;
  logic signed [RND_W-1:0]    shifted;
  logic signed [SAMPLE_W-1:0] y_sat;
  logic                       out_free;
  logic                       job_end;
  logic                       last_job;

  // input handshake
  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // coefficient load decode
  assign coef_we    = in_acc && (in_data.operation == OP_LOAD) &&
                      (int'(in_data.coef_index) < COEF_WORDS);
  assign coef_waddr = CA_W'(in_data.coef_index);

  // sequencer addressing
  assign row       = {sec, ch};
  assign coef_re   = (state == ST_RUN) && (tap < 3'd5);
  assign coef_addr = coef_base + CA_W'(tap);
  assign hist_re   = (state == ST_RUN) && (tap == 3'd0);
  assign job_end   = (state == ST_RUN) && (tap == TAP_LAST);
  assign hist_we   = job_end;
  assign last_job  = ch && (sec == SEC_W'(SECTIONS - 1));

  // history reads as zero until the row is written after reset or clear
  assign hist_cur = row_hit ? hist_rd : '0;
  assign x_cur    = ch ? cur_r : cur_l;

  // operand for the tap whose coefficient arrives this cycle
  always_comb begin
    case (tap)
      3'd1:    opnd = OPND_W'(x_cur);
      3'd2:    opnd = OPND_W'(hist_cur.x1);
      3'd3:    opnd = OPND_W'(hist_cur.x2);
      3'd4:    opnd = -OPND_W'(hist_cur.y1);
      3'd5:    opnd = -OPND_W'(hist_cur.y2);
      default: opnd = '0;
    endcase
  end

  // round half up, scale down and saturate
  always_comb begin
    rnd     = RND_W'(acc) + RND_HALF;
    shifted = rnd >>> COEF_FRAC_BITS;
    if (shifted > SAT_HI) begin
      y_sat = SAMPLE_W'(SAT_HI);
    end else if (shifted < SAT_LO) begin
      y_sat = SAMPLE_W'(SAT_LO);
    end else begin
      y_sat = shifted[SAMPLE_W-1:0];
    end
  end

  // new history row for the section just finished
  always_comb begin
    hist_wr.x1 = x_cur;
    hist_wr.x2 = hist_cur.x1;
    hist_wr.y1 = y_sat;
    hist_wr.y2 = hist_cur.y1;
  end

  // bypass register
  always_ff @(posedge clk) begin
    if (rst) begin
      bypass <= 1'b1;
    end else if (cfg_we) begin
      bypass <= cfg_wdata;
    end
  end

  // coefficient memory
  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[coef_waddr] <= in_data.coef_value;
    end
    if (coef_re) begin
      coef_rd <= coef_mem[coef_addr];
    end
  end

  // history memory
  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[row] <= hist_wr;
    end
    if (hist_re) begin
      hist_rd <= hist_mem[row];
      row_hit <= row_vld[row];
    end
  end

  // row valid bits
  always_ff @(posedge clk) begin
    if (rst || (in_acc && (in_data.operation == OP_CLEAR))) begin
      row_vld <= '0;
    end else if (hist_we) begin
      row_vld[row] <= 1'b1;
    end
  end

  // multiply and accumulate
  always_ff @(posedge clk) begin
    prod <= coef_rd * opnd;
    if (tap == 3'd2) begin
      acc <= ACC_W'(prod);
    end else if (tap > 3'd2 && tap < TAP_LAST) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      sec       <= '0;
      ch        <= 1'b0;
      tap       <= '0;
      coef_base <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_acc && (in_data.operation == OP_PROCESS)) begin
            sec       <= '0;
            ch        <= 1'b0;
            tap       <= '0;
            coef_base <= '0;
            state     <= bypass ? ST_FINISH : ST_RUN;
          end
        end
        ST_RUN: begin
          if (job_end) begin
            tap <= '0;
            ch  <= !ch;
            if (ch) begin
              sec       <= sec + SEC_W'(1);
              coef_base <= coef_base + CA_W'(5);
            end
            if (last_job) begin
              state <= ST_FINISH;
            end
          end else begin
            tap <= tap + 3'd1;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // running sample per channel
  always_ff @(posedge clk) begin
    if (in_acc && (in_data.operation == OP_PROCESS)) begin
      cur_l <= in_data.left_in;
      cur_r <= in_data.right_in;
    end else if (job_end) begin
      if (ch) begin
        cur_r <= y_sat;
      end else begin
        cur_l <= y_sat;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_FINISH) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_FINISH) && out_free) begin
      out_data.left_out  <= cur_l;
      out_data.right_out <= cur_r;
    end
  end

`ifndef ASSERT_OFF
  // a clear transaction invalidates every history row
  a_clear_rows: assert property (@(posedge clk) disable iff (rst)
    (in_acc && (in_data.operation == OP_CLEAR)) |=> (row_vld == '0))
    else $error("history rows still valid after clear");

  // a new result only follows the finish step
  a_out_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_FINISH))
    else $error("result shown without finish step");

  // a filtered pair starts at the first section, left channel, first tap
  a_run_start: assert property (@(posedge clk) disable iff (rst)
    (in_acc && (in_data.operation == OP_PROCESS) && !bypass) |=>
      ((state == ST_RUN) && (sec == '0) && !ch && (tap == '0) && (coef_base == '0)))
    else $error("sequencer did not start at the first section");
`endif

endmodule

`default_nettype wire
